[sv/hbs_pkg.sv]
// hbs_pkg: shared types and constants for the heightmap box smoothing block.
// No dependencies; imported by heightmap_box_smoothing and tb.

package hbs_pkg;

    // field and counter widths
    localparam int SAMPLE_W   = 16;  // Q8.8 height sample
    localparam int COL_W      = 6;   // column counter, map_width register
    localparam int ROW_W      = 12;  // row counter
    localparam int ROWS_CFG_W = 13;  // map_rows register
    localparam int STR_W      = 9;   // blend_strength register
    localparam int LAG_W      = 7;   // pending results, up to width+2
    localparam int BACK_W     = 7;   // distance back into the ring, up to 2*width+3
    localparam int SUM_W      = 20;  // signed sum of nine samples
    localparam int MAG_W      = 19;  // |sum|+4
    localparam int TAP_W      = 4;   // tap index of the 3x3 window

    // configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam logic [1:0] REG_MAP_WIDTH = 2'd0;
    localparam logic [1:0] REG_MAP_ROWS  = 2'd1;
    localparam logic [1:0] REG_STRENGTH  = 2'd2;

    localparam logic [COL_W-1:0]      RST_MAP_WIDTH = 6'd32;
    localparam logic [ROWS_CFG_W-1:0] RST_MAP_ROWS  = 13'd32;
    localparam logic [STR_W-1:0]      RST_STRENGTH  = 9'd128;
    localparam logic [STR_W-1:0]      STR_FULL      = 9'd256;

    // divide by nine: floor(x/9) = (x * RECIP_M) >> RECIP_SHIFT for x < 2^21
    localparam int          RECIP_W     = 21;
    localparam int          PROD_W      = MAG_W + RECIP_W;
    localparam int          RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_M = 21'd1864136;
    localparam logic [MAG_W-1:0]   ROUND_9 = 19'd4;

    // window taps, row above first
    localparam logic [TAP_W-1:0] TAP_FIRST  = 4'd0;
    localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;
    localparam logic [TAP_W-1:0] TAP_LAST   = 4'd8;

    // sequencer
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SETUP = 9'b000000010,
        ST_READ  = 9'b000000100,
        ST_WAIT  = 9'b000001000,
        ST_ABS   = 9'b000010000,
        ST_MUL   = 9'b000100000,
        ST_AVG   = 9'b001000000,
        ST_BLEND = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } t_state;

endpackage

[sv/hbs_ram.sv]
// hbs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/heightmap_box_smoothing.sv]
// heightmap_box_smoothing: streaming 3x3 box-filter blend over a height frame.
// Depends on hbs_pkg and hbs_ram.

// Height samples of one frame arrive in raster order and are kept in a ring
// RAM of RING_DEPTH words with one read port. A result trails its input by
// map_width+1 words; the frame's last input drains all pending results. A
// border result passes through accept, setup, one ring read, read wait and
// emit; an interior result makes nine ring reads through the single read port,
// then magnitude, divide-by-nine, mean and blend steps. The block accepts the
// next word once the pending result has been placed in the output register,
// even while that result still waits to be taken. Configuration writes to
// map_width or map_rows restart the frame and must be made while the block is
// idle.

module heightmap_box_smoothing #(
    parameter int MAX_WIDTH  = 62,
    parameter int MAX_ROWS   = 4096,
    parameter int RING_DEPTH = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [hbs_pkg::SAMPLE_W-1:0]    i_s_axis_tdata,   // [15:0] sample
    // output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [hbs_pkg::SAMPLE_W-1:0]    o_m_axis_tdata,   // [15:0] smoothed
    output logic                            o_m_axis_tlast,   // last_of_run
    output logic [0:0]                      o_m_axis_tuser,   // [0] frame_end
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hbs_pkg::CFG_AW-1:0]      paddr,
    input  logic [hbs_pkg::CFG_DW-1:0]      pwdata,
    output logic [hbs_pkg::CFG_DW-1:0]      prdata,
    output logic                            pready
);

    import hbs_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW:0] DEPTH_EXT = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0] WR_LAST = AW'(RING_DEPTH - 1);

    // reduce a distance into the ring modulo its depth (constant table)
    function automatic logic [AW-1:0] ring_mod(input logic [BACK_W-1:0] v);
        logic [AW-1:0] r;
        r = '0;
        for (int i = 0; i < 2**BACK_W; i++) begin
            if (v == BACK_W'(i)) r = AW'(i % RING_DEPTH);
        end
        return r;
    endfunction

    // configuration registers
    logic [COL_W-1:0]      r_map_width;
    logic [ROWS_CFG_W-1:0] r_map_rows;
    logic [STR_W-1:0]      r_strength;

    // frame and ring control
    t_state                r_state;
    logic [AW-1:0]         r_wr;
    logic [COL_W-1:0]      r_in_col, r_out_col;
    logic [ROW_W-1:0]      r_in_row, r_out_row;
    logic [LAG_W-1:0]      r_lag;
    logic                  r_drain;

    // window walk
    logic [BACK_W-1:0]     r_back;
    logic [TAP_W-1:0]      r_tap;
    logic [1:0]            r_dc;
    logic                  r_border;
    logic                  r_rd_pend, r_rd_center;

    // arithmetic
    logic signed [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0]        r_orig;
    logic                       r_neg;
    logic [MAG_W-1:0]           r_mag;
    logic [SAMPLE_W-1:0]        r_quot;
    logic signed [SAMPLE_W+1:0] r_diff;
    logic [SAMPLE_W-1:0]        r_blend;

    // output register
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_out_data;
    logic                  r_out_last, r_out_end;

    logic [COL_W-1:0]      w_eff;
    logic [ROWS_CFG_W-1:0] rows_eff;
    logic [STR_W-1:0]      s_eff;
    logic                  cfg_wr, in_acc, in_last, in_row_end, due, interior;
    logic                  emit_go, out_row_end;
    logic [1:0]            cfg_idx;
    logic [LAG_W-1:0]      lag_next, w_plus1;
    logic [AW-1:0]         back_mod, raddr;
    logic [AW:0]           addr_sum;
    logic                  ram_re;
    logic [SAMPLE_W-1:0]   rdata;
    logic [PROD_W-1:0]     prod;
    logic [SUM_W-1:0]      sum_abs;
    logic signed [SAMPLE_W:0]   avg;
    logic signed [27:0]    blend_full;
    logic signed [27:0]    diff_ext, str_ext, orig_ext;

    // effective geometry and strength
    always_comb begin
        if (r_map_width == '0) w_eff = COL_W'(1);
        else if (int'(r_map_width) > MAX_WIDTH) w_eff = COL_W'(MAX_WIDTH);
        else w_eff = r_map_width;

        if (r_map_rows == '0) rows_eff = ROWS_CFG_W'(1);
        else if (int'(r_map_rows) > MAX_ROWS) rows_eff = ROWS_CFG_W'(MAX_ROWS);
        else rows_eff = r_map_rows;

        s_eff = (r_strength > STR_FULL) ? STR_FULL : r_strength;
    end

    // APB access
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[CFG_AW-1:2];

    always_comb begin
        unique case (cfg_idx)
            REG_MAP_WIDTH: prdata = CFG_DW'(r_map_width);
            REG_MAP_ROWS:  prdata = CFG_DW'(r_map_rows);
            REG_STRENGTH:  prdata = CFG_DW'(r_strength);
            default:       prdata = '0;
        endcase
    end

    // input side position tracking
    assign in_acc     = i_s_axis_tvalid & o_s_axis_tready;
    assign in_row_end = ({1'b0, r_in_col} + (COL_W+1)'(1)) >= {1'b0, w_eff};
    assign in_last    = in_row_end &&
                        (({1'b0, r_in_row} + ROWS_CFG_W'(1)) >= rows_eff);
    assign lag_next   = r_lag + LAG_W'(1);
    assign w_plus1    = LAG_W'(w_eff) + LAG_W'(1);
    assign due        = lag_next > w_plus1;

    // output position and border test
    assign out_row_end = ({1'b0, r_out_col} + (COL_W+1)'(1)) >= {1'b0, w_eff};
    assign interior = (r_out_row != '0) &&
                      (({1'b0, r_out_row} + ROWS_CFG_W'(1)) < rows_eff) &&
                      (r_out_col != '0) && !out_row_end;

    // ring read address: (wr - back) mod depth
    assign back_mod = ring_mod(r_back);
    assign addr_sum = {1'b0, r_wr} + DEPTH_EXT - {1'b0, back_mod};
    assign raddr    = (addr_sum >= DEPTH_EXT) ? AW'(addr_sum - DEPTH_EXT) : AW'(addr_sum);
    assign ram_re   = (r_state == ST_READ);

    hbs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wr),
        .i_wdata (i_s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // divide by nine and blend datapath
    assign sum_abs  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign prod     = {{RECIP_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, RECIP_M};
    assign avg      = r_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});
    assign diff_ext = {{10{r_diff[SAMPLE_W+1]}}, r_diff};
    assign str_ext  = $signed({19'd0, s_eff});
    assign orig_ext = $signed({{4{r_orig[SAMPLE_W-1]}}, r_orig, 8'd0});
    assign blend_full = diff_ext * str_ext + orig_ext + 28'sd128;

    assign emit_go = !r_out_valid || i_m_axis_tready;

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map_width <= RST_MAP_WIDTH;
            r_map_rows  <= RST_MAP_ROWS;
            r_strength  <= RST_STRENGTH;
            r_wr        <= '0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_lag       <= '0;
            r_drain     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_center <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes, geometry changes restart the frame
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_MAP_WIDTH: begin
                        r_map_width <= pwdata[COL_W-1:0];
                        r_in_col <= '0; r_in_row <= '0;
                        r_out_col <= '0; r_out_row <= '0; r_lag <= '0;
                    end
                    REG_MAP_ROWS: begin
                        r_map_rows <= pwdata[ROWS_CFG_W-1:0];
                        r_in_col <= '0; r_in_row <= '0;
                        r_out_col <= '0; r_out_row <= '0; r_lag <= '0;
                    end
                    REG_STRENGTH: r_strength <= pwdata[STR_W-1:0];
                    default: ;
                endcase
            end

            // output register drains independently; emit loads it
            if (r_out_valid && i_m_axis_tready && (r_state != ST_EMIT))
                r_out_valid <= 1'b0;

            // read data from the ring lands in the cycle after the read
            r_rd_pend   <= (r_state == ST_READ);
            r_rd_center <= (r_state == ST_READ) && (r_border || (r_tap == TAP_CENTER));
            if (r_rd_pend) begin
                r_sum <= r_sum + $signed({{(SUM_W-SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata});
                if (r_rd_center) r_orig <= rdata;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_wr  <= (r_wr == WR_LAST) ? '0 : r_wr + AW'(1);
                        r_lag <= lag_next;
                        if (in_last) begin
                            r_in_col <= '0;
                            r_in_row <= '0;
                            r_drain  <= 1'b1;
                            r_state  <= ST_SETUP;
                        end else begin
                            if (in_row_end) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + ROW_W'(1);
                            end else begin
                                r_in_col <= r_in_col + COL_W'(1);
                            end
                            r_drain <= 1'b0;
                            if (due) r_state <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP: begin
                    r_sum    <= '0;
                    r_tap    <= TAP_FIRST;
                    r_dc     <= 2'd0;
                    r_border <= !interior;
                    r_back   <= interior ? (r_lag + BACK_W'(w_eff) + BACK_W'(1)) : r_lag;
                    r_state  <= ST_READ;
                end
                ST_READ: begin
                    r_tap       <= r_tap + TAP_W'(1);
                    if (r_dc == 2'd2) begin
                        r_dc   <= 2'd0;
                        r_back <= r_back - (BACK_W'(w_eff) - BACK_W'(2));
                    end else begin
                        r_dc   <= r_dc + 2'd1;
                        r_back <= r_back - BACK_W'(1);
                    end
                    if (r_border || (r_tap == TAP_LAST)) r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    r_state <= r_border ? ST_EMIT : ST_ABS;
                end
                ST_ABS: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_mag   <= sum_abs[MAG_W-1:0] + ROUND_9;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_quot  <= prod[RECIP_SHIFT +: SAMPLE_W];
                    r_state <= ST_AVG;
                end
                ST_AVG: begin
                    r_diff  <= {avg[SAMPLE_W], avg} -
                               $signed({{2{r_orig[SAMPLE_W-1]}}, r_orig});
                    r_state <= ST_BLEND;
                end
                ST_BLEND: begin
                    r_blend <= blend_full[8 +: SAMPLE_W];
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_border ? r_orig : r_blend;
                        r_out_last  <= !r_drain || (r_lag == LAG_W'(1));
                        r_out_end   <= r_drain && (r_lag == LAG_W'(1));
                        r_lag       <= r_lag - LAG_W'(1);
                        if (r_drain && (r_lag == LAG_W'(1))) begin
                            // frame done: restart output position
                            r_out_col <= '0;
                            r_out_row <= '0;
                            r_drain   <= 1'b0;
                            r_state   <= ST_IDLE;
                        end else begin
                            if (out_row_end) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + ROW_W'(1);
                            end else begin
                                r_out_col <= r_out_col + COL_W'(1);
                            end
                            r_state <= r_drain ? ST_SETUP : ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_end;

endmodule

[sv/hbs_checker.sv]
// hbs_checker: port-level assertions for heightmap_box_smoothing, bound to the top.
// No package dependencies; attached by the bind at the end of this file.

module hbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [0:0]  o_m_axis_tuser
);

    // a stalled output word stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    // and keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    // the frame's final word closes its run
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast)
        else $error("frame end without run end");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output word valid out of reset");

endmodule

bind heightmap_box_smoothing hbs_checker u_hbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[bench/tb.sv]
// tb: self-checking bench for heightmap_box_smoothing, 3x3 box blend over raster frames.
// Depends on hbs_pkg and heightmap_box_smoothing; a built-in predictor tracks the ring and counters.

module tb;

    import hbs_pkg::*;

    localparam int RING          = 128;
    localparam int MAX_W         = 62;
    localparam int MAX_R         = 4096;
    localparam int MAX_RESULTS   = 64;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;

    localparam logic [CFG_AW-1:0] ADDR_WIDTH    = {REG_MAP_WIDTH, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_ROWS     = {REG_MAP_ROWS, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_STRENGTH = {REG_STRENGTH, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_SPARE    = 4'hC;    // past the register list

    // 3x3 frames for the directed part
    localparam logic [15:0] RIDGE [9] = '{16'h7FFF, 16'h8000, 16'h0001,
                                          16'hFFFF, 16'h1234, 16'h0000,
                                          16'h8000, 16'h7FFF, 16'h5555};
    localparam logic [15:0] SLOPE [9] = '{16'h0100, 16'hFF00, 16'h0080,
                                          16'h4000, 16'hC000, 16'h2000,
                                          16'h0000, 16'h7FFF, 16'h8001};

    typedef struct packed {
        logic [15:0] smoothed;
        logic        last_of_run;
        logic        frame_end;
    } t_height_word;

    typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CFG_AW-1:0] addr;
        logic [31:0]       data;      // register value or sample
        bit                typed;     // smoothed value given in typed_v
        logic [15:0]       typed_v;
    } t_script_row;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [SAMPLE_W-1:0]   i_s_axis_tdata = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic [0:0]            o_m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_AW-1:0]     paddr = '0;
    logic [CFG_DW-1:0]     pwdata = '0;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    // predictor state
    logic [15:0]       ring [RING];
    int                ring_ptr;
    int                col_in, row_in, col_out, row_out, lag;
    logic [5:0]        cfg_width;
    logic [12:0]       cfg_rows;
    logic [8:0]        cfg_strength;

    t_height_word      step_words [$];
    t_height_word      heights_due [$];
    t_script_row       script [$];

    int  errors;
    int  words_checked;
    int  frames_done;
    int  directed_sent;
    int  random_sent;
    int  settings_done;
    int  squeeze_count;
    bit  sender_burst;

    heightmap_box_smoothing dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),    // [15:0] sample
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // [15:0] smoothed
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),    // [0] frame_end
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return int'(cfg_width);
    endfunction

    function automatic int eff_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > MAX_R) return MAX_R;
        return int'(cfg_rows);
    endfunction

    // sample written 'back' words ago, 1 is the newest
    function automatic int ring_at(int back);
        int idx;
        logic signed [15:0] h;
        idx = (ring_ptr + RING - (back % RING)) % RING;
        h = ring[idx];
        return h;
    endfunction

    function automatic logic [15:0] blend_at(int back);
        int     w, rows, orig, sum, avg, s, dr, dc;
        longint v;
        w = eff_width();
        rows = eff_rows();
        orig = ring_at(back);
        // borders pass through
        if (!(row_out >= 1 && row_out + 1 < rows && col_out >= 1 && col_out + 1 < w))
            return orig[15:0];
        sum = 0;
        for (dr = -1; dr <= 1; dr++)
            for (dc = -1; dc <= 1; dc++)
                sum += ring_at(back - (dr * w + dc));
        avg = (sum >= 0) ? (sum + 4) / 9 : -((-sum + 4) / 9);
        s = (cfg_strength > STR_FULL) ? 256 : int'(cfg_strength);
        v = longint'(orig) * (256 - s) + longint'(avg) * s + 128;
        v = v >>> 8;
        return v[15:0];
    endfunction

    function automatic void advance_out(int w);
        if (col_out + 1 >= w) begin
            col_out = 0;
            row_out = (row_out + 1) & 'hFFF;
        end else begin
            col_out++;
        end
    endfunction

    function automatic void restart_frame();
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
        lag = 0;
    endfunction

    // one accepted sample; results land in step_words
    function automatic void smooth_step(logic [15:0] v);
        int           w, rows;
        bit           last;
        t_height_word hw;
        w = eff_width();
        rows = eff_rows();
        step_words.delete();
        ring[ring_ptr] = v;
        ring_ptr = (ring_ptr + 1) % RING;
        last = (row_in + 1 >= rows) && (col_in + 1 >= w);
        if (last) begin
            col_in = 0;
            row_in = 0;
        end else if (col_in + 1 >= w) begin
            col_in = 0;
            row_in = (row_in + 1) & 'hFFF;
        end else begin
            col_in++;
        end
        lag++;
        if (last) begin
            // frame end drains everything pending
            while (lag > 0 && step_words.size() < MAX_RESULTS) begin
                hw.smoothed = blend_at(lag);
                hw.last_of_run = 1'b0;
                hw.frame_end = (lag == 1);
                step_words.insert(step_words.size(), hw);
                advance_out(w);
                lag--;
            end
            restart_frame();
        end else if (lag > w + 1) begin
            hw.smoothed = blend_at(lag);
            hw.last_of_run = 1'b0;
            hw.frame_end = 1'b0;
            step_words.insert(step_words.size(), hw);
            advance_out(w);
            lag--;
        end
        if (step_words.size() != 0)
            step_words[step_words.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic void apply_reg(logic [CFG_AW-1:0] a, logic [31:0] d);
        case (a)
            ADDR_WIDTH: begin
                cfg_width = d[5:0];
                restart_frame();
            end
            ADDR_ROWS: begin
                cfg_rows = d[12:0];
                restart_frame();
            end
            ADDR_STRENGTH: cfg_strength = d[8:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_mask(logic [CFG_AW-1:0] a);
        case (a)
            ADDR_WIDTH:    return 32'h3F;
            ADDR_ROWS:     return 32'h1FFF;
            ADDR_STRENGTH: return 32'h1FF;
            default:       return 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] reg_copy(logic [CFG_AW-1:0] a);
        case (a)
            ADDR_WIDTH:    return 32'(cfg_width);
            ADDR_ROWS:     return 32'(cfg_rows);
            ADDR_STRENGTH: return 32'(cfg_strength);
            default:       return 32'h0;
        endcase
    endfunction

    // ---------------- drivers ----------------

    function automatic int pick_gap();
        int r;
        if (sender_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic offer_sample(input logic [15:0] v, input bit typed,
                                input logic [15:0] typed_v);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= v;
        do @(posedge i_clk); while (!o_s_axis_tready);
        smooth_step(v);
        if (typed && step_words.size() != 0)
            step_words[step_words.size() - 1].smoothed = typed_v;
        foreach (step_words[j]) begin
            heights_due.insert(heights_due.size(), step_words[j]);
            if (step_words[j].frame_end) frames_done++;
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering, let pending words out, then give the sequencer time to go idle
    task automatic settle();
        if (i_s_axis_tvalid) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        while (heights_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [CFG_AW-1:0] a,
                              input logic [31:0] d, output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [31:0] d);
        logic [31:0] rd;
        settle();
        apb_access(1'b1, a, d, rd);
        apply_reg(a, d);
        settings_done++;
    endtask

    task automatic check_reg(input logic [CFG_AW-1:0] a, input logic [31:0] want);
        logic [31:0] rd;
        settle();
        apb_access(1'b0, a, '0, rd);
        if ((rd & reg_mask(a)) !== (want & reg_mask(a))) begin
            errors++;
            $display("%0t: register at %h expected %h got %h", $time, a,
                     want & reg_mask(a), rd & reg_mask(a));
        end
    endtask

    task automatic add_row(input t_row_kind k, input logic [CFG_AW-1:0] a,
                           input logic [31:0] d, input bit typed,
                           input logic [15:0] typed_v);
        t_script_row row;
        row.kind = k;
        row.addr = a;
        row.data = d;
        row.typed = typed;
        row.typed_v = typed_v;
        script.insert(script.size(), row);
    endtask

    // ---------------- output side: checker and back-pressure ----------------

    initial begin : drain_side
        int           stall_left;
        int           hold_left;
        int           squeeze_seen;
        bit           calm;
        t_height_word want;
        stall_left = 0;
        hold_left = 0;
        squeeze_seen = 0;
        calm = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                words_checked++;
                if (heights_due.size() == 0) begin
                    errors++;
                    $display("%0t: word %h with nothing expected", $time, o_m_axis_tdata);
                end else begin
                    want = heights_due.pop_front();
                    if (o_m_axis_tdata !== want.smoothed) begin
                        errors++;
                        $display("%0t: smoothed expected %h got %h", $time,
                                 want.smoothed, o_m_axis_tdata);
                    end
                    if (o_m_axis_tlast !== want.last_of_run) begin
                        errors++;
                        $display("%0t: last_of_run expected %b got %b", $time,
                                 want.last_of_run, o_m_axis_tlast);
                    end
                    if (o_m_axis_tuser[0] !== want.frame_end) begin
                        errors++;
                        $display("%0t: frame_end expected %b got %b", $time,
                                 want.frame_end, o_m_axis_tuser[0]);
                    end
                end
            end
            // long hold-off asked for by the sender side
            if (squeeze_seen != squeeze_count) begin
                squeeze_seen = squeeze_count;
                hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(0, 99) == 0) calm = !calm;
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles, %0d still expected", $time,
                 QUIET_LIMIT, heights_due.size());
        $display("heightmap_box_smoothing verification failed");
        $finish;
    end

    // ---------------- stimulus ----------------

    initial begin : stimulus
        int          pick, w_cfg, r_cfg, s_cfg, w, frames, count, style, mid;
        bit          partial;
        logic [31:0] junk;
        logic [15:0] v, level;

        ring_ptr = 0;
        foreach (ring[i]) ring[i] = '0;
        restart_frame();
        cfg_width = RST_MAP_WIDTH;
        cfg_rows = RST_MAP_ROWS;
        cfg_strength = RST_STRENGTH;

        // directed part: reset values, a full-strength 3x3 frame with extreme
        // samples, a zero-strength frame, degenerate 1x1 geometry, a spare address
        add_row(ROW_READ, ADDR_WIDTH, 32'(RST_MAP_WIDTH), 0, '0);
        add_row(ROW_READ, ADDR_ROWS, 32'(RST_MAP_ROWS), 0, '0);
        add_row(ROW_READ, ADDR_STRENGTH, 32'(RST_STRENGTH), 0, '0);
        add_row(ROW_WRITE, ADDR_WIDTH, 32'd3, 0, '0);
        add_row(ROW_WRITE, ADDR_ROWS, 32'd3, 0, '0);
        add_row(ROW_WRITE, ADDR_STRENGTH, 32'(STR_FULL), 0, '0);
        add_row(ROW_READ, ADDR_WIDTH, 32'd3, 0, '0);
        // words 4..7 each release one border sample, unchanged
        for (int k = 0; k < 9; k++)
            add_row(ROW_SAMPLE, '0, 32'(RIDGE[k]), (k >= 4 && k <= 7),
                    (k >= 4 && k <= 7) ? RIDGE[(k + 5) % 9] : 16'h0);
        add_row(ROW_WRITE, ADDR_STRENGTH, 32'd0, 0, '0);
        for (int k = 0; k < 9; k++)
            add_row(ROW_SAMPLE, '0, 32'(SLOPE[k]), 0, '0);
        // zero width and zero rows act as 1: every word is its own frame
        add_row(ROW_WRITE, ADDR_WIDTH, 32'd0, 0, '0);
        add_row(ROW_WRITE, ADDR_ROWS, 32'd0, 0, '0);
        add_row(ROW_READ, ADDR_ROWS, 32'd0, 0, '0);
        add_row(ROW_SAMPLE, '0, 32'h8000, 1, 16'h8000);
        add_row(ROW_SAMPLE, '0, 32'h7FFF, 1, 16'h7FFF);
        add_row(ROW_WRITE, ADDR_SPARE, 32'h3, 0, '0);
        add_row(ROW_SAMPLE, '0, 32'h1357, 1, 16'h1357);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_WRITE: write_reg(script[i].addr, script[i].data);
                ROW_READ:  check_reg(script[i].addr, script[i].data);
                default: begin
                    offer_sample(script[i].data[15:0], script[i].typed, script[i].typed_v);
                    directed_sent++;
                end
            endcase
        end

        // random part: one geometry and starting strength per pass, small frames mostly
        level = '0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 15);
            partial = 1'b0;
            case (pick)
                0: begin w_cfg = 0; r_cfg = $urandom_range(1, 4); end
                1: begin w_cfg = 63; r_cfg = $urandom_range(0, 2); end
                2: begin w_cfg = 62; r_cfg = $urandom_range(2, 3); end
                3: begin w_cfg = $urandom_range(1, 2); r_cfg = $urandom_range(1, 6); end
                4: begin w_cfg = $urandom_range(3, 8); r_cfg = $urandom_range(0, 2); end
                5: begin
                    // rows past the maximum; frame cut short by the next geometry write
                    w_cfg = $urandom_range(3, 8);
                    r_cfg = $urandom_range(MAX_R + 1, 8191);
                    partial = 1'b1;
                end
                default: begin w_cfg = $urandom_range(3, 10); r_cfg = $urandom_range(3, 6); end
            endcase
            case ($urandom_range(0, 7))
                0:       s_cfg = 0;
                1:       s_cfg = 256;
                2:       s_cfg = $urandom_range(257, 511);   // saturates
                default: s_cfg = $urandom_range(1, 255);
            endcase
            junk = ($urandom_range(0, 3) == 0) ? ($urandom() & 32'hFFFF_E000) : 32'h0;
            write_reg(ADDR_STRENGTH, junk | 32'(s_cfg));
            if ($urandom_range(0, 1) == 0) begin
                write_reg(ADDR_WIDTH, junk | 32'(w_cfg));
                write_reg(ADDR_ROWS, junk | 32'(r_cfg));
            end else begin
                write_reg(ADDR_ROWS, junk | 32'(r_cfg));
                write_reg(ADDR_WIDTH, junk | 32'(w_cfg));
            end
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0:       check_reg(ADDR_WIDTH, reg_copy(ADDR_WIDTH));
                    1:       check_reg(ADDR_ROWS, reg_copy(ADDR_ROWS));
                    default: check_reg(ADDR_STRENGTH, reg_copy(ADDR_STRENGTH));
                endcase
            end

            w = eff_width();
            if (partial) frames = 1;
            else if (w * eff_rows() > 60) frames = 1;
            else frames = $urandom_range(1, 3);

            for (int f = 0; f < frames; f++) begin
                count = partial ? w * $urandom_range(2, 4) + $urandom_range(0, w - 1)
                                : w * eff_rows();
                style = $urandom_range(0, 3);
                sender_burst = ($urandom_range(0, 3) == 0);
                mid = (count > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, count - 1)
                                                               : -1;
                level = 16'($urandom());
                for (int k = 0; k < count; k++) begin
                    // strength changes take effect mid-frame
                    if (k == mid) write_reg(ADDR_STRENGTH, 32'($urandom_range(0, 511)));
                    case (style)
                        0: v = 16'($urandom());
                        1: begin
                            level = level + 16'($urandom_range(0, 64)) - 16'd32;
                            v = level;
                        end
                        2: case ($urandom_range(0, 3))
                            0:       v = 16'h7FFF;
                            1:       v = 16'h8000;
                            2:       v = 16'h0000;
                            default: v = 16'hFFFF;
                        endcase
                        default: v = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : level;
                    endcase
                    if (random_sent == 100 || random_sent == 320) squeeze_count++;
                    offer_sample(v, 1'b0, '0);
                    random_sent++;
                end
            end
            sender_burst = 1'b0;
        end

        settle();
        $display("covered %0d directed and %0d random samples, %0d register writes, %0d frames",
                 directed_sent, random_sent, settings_done, frames_done);
        $display("checked %0d smoothed words, %0d mismatches", words_checked, errors);
        if (errors == 0)
            $display("heightmap_box_smoothing verification clean");
        else
            $display("heightmap_box_smoothing verification failed");
        $finish;
    end

endmodule
